### rtl/nqbc_pkg.sv
// Shared constants, types and controller states for the N-queens solution counter.
`timescale 1ns / 1ps
`default_nettype none

package nqbc_pkg;

    localparam int MAX_BOARD_DEF = 16;
    localparam int FIRST_W       = 4;
    localparam int CFG_W         = 5;
    localparam int COUNT_W       = 24;

    localparam logic [CFG_W-1:0]   BOARD_RESET = CFG_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUMP,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;
        logic step;
        logic bump;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish;
    } stat_t;

endpackage

`default_nettype wire

### rtl/nqbc_datapath.sv
// Search datapath: placement stack, row and diagonal masks, candidate search and counter.
`timescale 1ns / 1ps
`default_nettype none

module nqbc_datapath #(
    parameter int MAX_BOARD = nqbc_pkg::MAX_BOARD_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  nqbc_pkg::cmd_t                       cmd,
    input  wire  [$clog2(MAX_BOARD+1)-1:0]       board_n,
    input  wire  [nqbc_pkg::FIRST_W-1:0]         first_row,
    output nqbc_pkg::stat_t                      status,
    output logic [nqbc_pkg::COUNT_W-1:0]         solution_count
);
    import nqbc_pkg::*;

    localparam int COL_W = $clog2(MAX_BOARD + 1);
    localparam int SW    = $clog2(MAX_BOARD);
    localparam int DN    = 2 * MAX_BOARD - 1;
    localparam int DIW   = $clog2(DN);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   next_reg, next_next;
    logic [MAX_BOARD-1:0] rows_reg, rows_next;
    logic [DN-1:0]      d1_reg, d1_next;
    logic [DN-1:0]      d2_reg, d2_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [SW-1:0]      stack_reg [MAX_BOARD];

    logic               stack_we;
    logic [SW-1:0]      stack_waddr;
    logic [SW-1:0]      stack_wdata;

    logic [MAX_BOARD-1:0] cand;
    logic [SW-1:0]      sel;
    logic               placed;
    logic               last_col;
    logic               bump;
    logic [COL_W-1:0]   prev_col;
    logic [SW-1:0]      prev_row;
    logic [SW-1:0]      first_sw;

    // A row is a candidate when it lies in the board, at or after the resume
    // point, and its row and both diagonals are free of earlier queens.
    always_comb begin
        logic [DIW-1:0] i1;
        logic [DIW-1:0] i2;
        cand = '0;
        for (int r = 0; r < MAX_BOARD; r++) begin
            i1 = DIW'(r) + DIW'(col_reg);
            i2 = DIW'(r) + DIW'(MAX_BOARD - 1) - DIW'(col_reg);
            cand[r] = (COL_W'(r) < board_n) && (COL_W'(r) >= next_reg) &&
                      !rows_reg[r] && !d1_reg[i1] && !d2_reg[i2];
        end
        sel = '0;
        for (int r = MAX_BOARD - 1; r >= 0; r--) begin
            if (cand[r]) begin
                sel = SW'(r);
            end
        end
    end

    assign placed   = |cand;
    assign last_col = (col_reg == board_n - COL_W'(1));
    assign prev_col = col_reg - COL_W'(1);
    assign prev_row = stack_reg[prev_col[SW-1:0]];
    assign first_sw = SW'(first_row);
    assign bump     = cmd.bump || (cmd.step && placed && last_col);

    assign status.finish = !placed && (col_reg == COL_W'(1));

    always_comb begin
        col_next    = col_reg;
        next_next   = next_reg;
        rows_next   = rows_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        stack_we    = 1'b0;
        stack_waddr = col_reg[SW-1:0];
        stack_wdata = sel;
        if (cmd.init) begin
            rows_next = '0;
            d1_next   = '0;
            d2_next   = '0;
            rows_next[first_sw] = 1'b1;
            d1_next[DIW'(first_sw)] = 1'b1;
            d2_next[DIW'(first_sw) + DIW'(MAX_BOARD - 1)] = 1'b1;
            col_next    = COL_W'(1);
            next_next   = '0;
            stack_we    = 1'b1;
            stack_waddr = '0;
            stack_wdata = first_sw;
        end else if (cmd.step) begin
            if (placed) begin
                stack_we = 1'b1;
                if (last_col) begin
                    next_next = COL_W'(sel) + COL_W'(1);
                end else begin
                    rows_next[sel] = 1'b1;
                    d1_next[DIW'(sel) + DIW'(col_reg)] = 1'b1;
                    d2_next[DIW'(sel) + DIW'(MAX_BOARD - 1) - DIW'(col_reg)] = 1'b1;
                    col_next  = col_reg + COL_W'(1);
                    next_next = '0;
                end
            end else if (col_reg != COL_W'(1)) begin
                // Backtrack: lift the queen of the previous column and resume after it.
                rows_next[prev_row] = 1'b0;
                d1_next[DIW'(prev_row) + DIW'(prev_col)] = 1'b0;
                d2_next[DIW'(prev_row) + DIW'(MAX_BOARD - 1) - DIW'(prev_col)] = 1'b0;
                col_next  = prev_col;
                next_next = COL_W'(prev_row) + COL_W'(1);
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.init) begin
            count_next = '0;
        end else if (bump && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            count_reg <= '0;
        end else begin
            col_reg   <= col_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        next_reg <= next_next;
        rows_reg <= rows_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        if (cmd.load_out) begin
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_reg[stack_waddr] <= stack_wdata;
        end
    end

    assign solution_count = out_count_reg;

endmodule

`default_nettype wire

### rtl/nqbc_ctrl.sv
// Controller: board size register, input check, search sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module nqbc_ctrl #(
    parameter int MAX_BOARD = nqbc_pkg::MAX_BOARD_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [nqbc_pkg::FIRST_W-1:0]      first_row,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic                              bad_start,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [nqbc_pkg::CFG_W-1:0]        cfg_data,
    output logic [$clog2(MAX_BOARD+1)-1:0]    board_n,
    output nqbc_pkg::cmd_t                    cmd,
    input  nqbc_pkg::stat_t                   status
);
    import nqbc_pkg::*;

    localparam int COL_W = $clog2(MAX_BOARD + 1);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  board_reg;
    logic [CFG_W-1:0]  n_clamp;
    logic              bad_reg, bad_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_bad_reg;
    logic              in_xfer;
    logic              out_free;
    logic              bad_now;

    assign cfg_ready = 1'b1;
    assign n_clamp   = (board_reg > CFG_W'(MAX_BOARD)) ? CFG_W'(MAX_BOARD) : board_reg;
    assign board_n   = n_clamp[COL_W-1:0];
    assign bad_now   = (CFG_W'(first_row) >= n_clamp);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.init = 1'b1;
                    bad_next = bad_now;
                    if (bad_now) begin
                        state_next = ST_DONE;
                    end else if (n_clamp == CFG_W'(1)) begin
                        state_next = ST_BUMP;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_BUMP: begin
                // A single queen on a board of one is a complete placement.
                cmd.bump   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (status.finish) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            board_reg   <= BOARD_RESET;
            m_valid_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bad_reg     <= bad_next;
            if (cfg_valid && cfg_ready) begin
                board_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_bad_reg <= bad_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign bad_start = m_bad_reg;

endmodule

`default_nettype wire

### rtl/nqueens_backtrack_counter.sv
// Top level of the N-queens backtracking solution counter with a fixed first queen.
// Sequencing: a bad start row goes from the input transfer straight to the result load; a
// board of one counts its single placement first; otherwise the search steps once per queen
// placed, per complete placement counted and per backtrack, until the second column is exhausted.
// Throughput: one item at a time; the next input transfer is taken once the result is loaded.
// Reset: board size 8, result channel empty; the placement stack is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nqueens_backtrack_counter #(
    parameter int MAX_BOARD = nqbc_pkg::MAX_BOARD_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [3:0] first_row, [7:4] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [23:0] solution_count
    output logic [0:0]  m_tuser,   // [0] bad_start
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data   // [4:0] board_size
);
    import nqbc_pkg::*;

    localparam int COL_W = $clog2(MAX_BOARD + 1);

    cmd_t               cmd;
    stat_t              status;
    logic [COL_W-1:0]   board_n;
    logic               bad_start;
    logic [COUNT_W-1:0] solution_count;

    nqbc_ctrl #(
        .MAX_BOARD (MAX_BOARD)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .first_row (s_tdata[3:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .bad_start (bad_start),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .board_n   (board_n),
        .cmd       (cmd),
        .status    (status)
    );

    nqbc_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .board_n        (board_n),
        .first_row      (s_tdata[3:0]),
        .status         (status),
        .solution_count (solution_count)
    );

    assign m_tdata    = solution_count;
    assign m_tuser[0] = bad_start;

endmodule

`default_nettype wire
